// File: rtl/core/ctt_pkg.sv
// Shared types and constants for the callback timer table.
`default_nettype none

package ctt_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int FIRE_CNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int WIDE_IDX_W    = 7;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_REG    = 2'd1,
    OP_DEREG  = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    KIND_REGISTERED   = 3'd0,
    KIND_FULL         = 3'd1,
    KIND_DEREGISTERED = 3'd2,
    KIND_NOT_FOUND    = 3'd3,
    KIND_FIRED        = 3'd4,
    KIND_IDLE         = 3'd5
  } kind_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [9:0]  period;
    logic        rep;
    logic [9:0]  countdown;
  } entry_t;

endpackage

`default_nettype wire

// File: rtl/core/ctt_if.sv
// Request and response channel interfaces of the callback timer table.
`default_nettype none

interface ctt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] handle;
  logic [9:0]  period;
  logic        repeat_req;

  modport source (output valid, opcode, handle, period, repeat_req, input ready);
  modport sink (input valid, opcode, handle, period, repeat_req, output ready);
endinterface

interface ctt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  slot;
  logic [15:0] fired_handle;
  logic        last;

  modport source (output valid, kind, slot, fired_handle, last, input ready);
  modport sink (input valid, kind, slot, fired_handle, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ctt_slot_mem.sv
// Slot memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module ctt_slot_mem #(
  parameter int NUM_SLOTS = ctt_pkg::NUM_SLOTS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  wire logic [IDX_W-1:0] wr_idx,
  input  wire ctt_pkg::entry_t wr_entry,
  input  wire logic            rd_en,
  input  wire logic [IDX_W-1:0] rd_idx,
  output ctt_pkg::entry_t      rd_entry
);

  ctt_pkg::entry_t mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] written;
  ctt_pkg::entry_t rd_data;
  logic rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  // An entry never written since reset reads as a free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok <= written[rd_idx];
      end
    end
  end

  assign rd_entry = rd_ok ? rd_data : '0;

endmodule

`default_nettype wire

// File: rtl/core/ctt_seq.sv
// Sequencer: walks the slot memory, applies updates and produces result items.
`default_nettype none

module ctt_seq #(
  parameter int NUM_SLOTS = ctt_pkg::NUM_SLOTS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int CNT_W = $clog2(NUM_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  ctt_req_if.sink               req,
  ctt_rsp_if.source             rsp,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_idx,
  output ctt_pkg::entry_t       wr_entry,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_idx,
  input  wire ctt_pkg::entry_t  rd_entry
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;
  ctt_pkg::op_t op;
  logic [15:0] req_handle;
  logic [9:0]  req_period;
  logic        req_rep;

  logic [CNT_W-1:0] rd_cnt;
  logic             pr_valid;
  logic             pr_last;
  logic [IDX_W-1:0] pr_idx;
  logic [ctt_pkg::FIRE_CNT_W-1:0] fire_cnt;

  // The most recent reportable result; it goes out with last once the walk ends.
  logic            pend_valid;
  ctt_pkg::kind_t  pend_kind;
  logic [2:0]      pend_slot;
  logic [15:0]     pend_handle;

  logic            out_valid;
  ctt_pkg::kind_t  out_kind;
  logic [2:0]      out_slot;
  logic [15:0]     out_handle;
  logic            out_last;

  logic [ctt_pkg::WIDE_IDX_W-1:0] pr_idx_wide;
  logic [2:0] pr_slot;
  logic busy, fire, hit, report, need_out, out_free, advance, issue, out_load;
  ctt_pkg::kind_t done_kind;

  assign pr_idx_wide = ctt_pkg::WIDE_IDX_W'(pr_idx);
  assign pr_slot     = pr_idx_wide[2:0];

  always_comb begin
    busy = |rd_entry.handle;
    fire = 1'b0;
    hit  = 1'b0;
    done_kind = ctt_pkg::KIND_IDLE;
    wr_entry = '0;
    case (op)
      ctt_pkg::OP_TICK: begin
        fire = busy && (rd_entry.countdown == '0);
        wr_entry = rd_entry;
        if (fire) begin
          if (rd_entry.rep) begin
            wr_entry.countdown = rd_entry.period;
          end else begin
            wr_entry = '0;
          end
        end else begin
          wr_entry.countdown = rd_entry.countdown - 10'd1;
        end
      end
      ctt_pkg::OP_REG: begin
        hit = (|req_handle) && !busy;
        done_kind = ctt_pkg::KIND_FULL;
        wr_entry.handle    = req_handle;
        wr_entry.period    = req_period;
        wr_entry.rep       = req_rep;
        wr_entry.countdown = req_period;
      end
      ctt_pkg::OP_DEREG: begin
        hit = (|req_handle) && (rd_entry.handle == req_handle);
        done_kind = ctt_pkg::KIND_NOT_FOUND;
      end
      default: begin
        done_kind = ctt_pkg::KIND_IDLE;
      end
    endcase

    report   = fire && (fire_cnt < ctt_pkg::FIRE_CNT_W'(ctt_pkg::MAX_RESULTS));
    need_out = report && pend_valid;
    out_free = !out_valid || rsp.ready;
    advance  = (state == ST_SCAN) && pr_valid && (!need_out || out_free);
    issue    = (state == ST_SCAN) && (rd_cnt != CNT_W'(NUM_SLOTS)) &&
               (!pr_valid || (advance && !hit));
    wr_en    = advance && (((op == ctt_pkg::OP_TICK) && busy) || hit);
    out_load = (advance && need_out) || ((state == ST_DONE) && out_free);
  end

  assign wr_idx = pr_idx;
  assign rd_en  = issue;
  assign rd_idx = rd_cnt[IDX_W-1:0];

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_kind;
  assign rsp.slot         = out_slot;
  assign rsp.fired_handle = out_handle;
  assign rsp.last         = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pr_valid   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      rd_cnt     <= '0;
      fire_cnt   <= '0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          // The unused opcode is taken and dropped without a result.
          if (req.valid && (req.opcode != ctt_pkg::OP_UNUSED)) begin
            state      <= ST_SCAN;
            op         <= ctt_pkg::op_t'(req.opcode);
            req_handle <= req.handle;
            req_period <= req.period;
            req_rep    <= req.repeat_req;
            rd_cnt     <= '0;
            pr_valid   <= 1'b0;
            fire_cnt   <= '0;
            pend_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            pr_valid <= 1'b1;
            pr_idx   <= rd_cnt[IDX_W-1:0];
            pr_last  <= (rd_cnt == CNT_W'(NUM_SLOTS - 1));
            rd_cnt   <= rd_cnt + 1'b1;
          end else if (advance) begin
            pr_valid <= 1'b0;
          end
          if (advance) begin
            if (report) begin
              pend_valid  <= 1'b1;
              pend_kind   <= ctt_pkg::KIND_FIRED;
              pend_slot   <= pr_slot;
              pend_handle <= rd_entry.handle;
              fire_cnt    <= fire_cnt + 1'b1;
            end
            if (need_out) begin
              out_kind   <= pend_kind;
              out_slot   <= pend_slot;
              out_handle <= pend_handle;
              out_last   <= 1'b0;
            end
            if (hit) begin
              pend_valid  <= 1'b1;
              pend_kind   <= (op == ctt_pkg::OP_REG) ? ctt_pkg::KIND_REGISTERED
                                                     : ctt_pkg::KIND_DEREGISTERED;
              pend_slot   <= pr_slot;
              pend_handle <= req_handle;
            end
            if (hit || pr_last) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_last  <= 1'b1;
            if (pend_valid) begin
              out_kind   <= pend_kind;
              out_slot   <= pend_slot;
              out_handle <= pend_handle;
            end else begin
              out_kind   <= done_kind;
              out_slot   <= '0;
              out_handle <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/callback_timer_table_core.sv
// A tick walks all NUM_SLOTS slots, one per cycle through the slot memory's read port,
// and presents its final item once the walk ends. Register and deregister stop at the
// first hit. The block takes one item at a time; the next item is taken
// once the last result is loaded. Downstream stalls pause the walk between firings.
// Reset (rst, synchronous) empties every slot and drops any pending result item.
`default_nettype none

module callback_timer_table_core #(
  parameter int NUM_SLOTS = ctt_pkg::NUM_SLOTS_DEF,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input wire logic  clk,
  input wire logic  rst,
  ctt_req_if.sink   req,
  ctt_rsp_if.source rsp
);

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  ctt_pkg::entry_t  wr_entry;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  ctt_pkg::entry_t  rd_entry;

  ctt_slot_mem #(.NUM_SLOTS(NUM_SLOTS)) u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

  ctt_seq #(.NUM_SLOTS(NUM_SLOTS)) u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry)
  );

endmodule

`default_nettype wire

// File: rtl/core/ctt_checker.sv
// Port-level checker for the callback timer table, bound to the top level.
`default_nettype none

module ctt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  in_opcode,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_kind,
  input wire logic [2:0]  out_slot,
  input wire logic [15:0] out_handle,
  input wire logic        out_last
);

  // A result item waiting downstream is held until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_handle))
    else $error("result item changed while stalled");

  // Any real operation keeps the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_opcode != ctt_pkg::OP_UNUSED) |=> !in_ready)
    else $error("item accepted while previous operation still running");

  // Only firings can be followed by further results of the same item.
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_kind != ctt_pkg::KIND_FIRED) |-> out_last)
    else $error("single-result kind without last");

  // Results without a slot carry zero slot and handle.
  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_kind == ctt_pkg::KIND_IDLE) || (out_kind == ctt_pkg::KIND_FULL) ||
                  (out_kind == ctt_pkg::KIND_NOT_FOUND))
    |-> (out_slot == 3'd0) && (out_handle == 16'd0))
    else $error("empty result with nonzero slot or handle");

  // A slot that was written, freed or fired always has a nonzero handle.
  a_handle_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((out_kind == ctt_pkg::KIND_REGISTERED) ||
                  (out_kind == ctt_pkg::KIND_DEREGISTERED) ||
                  (out_kind == ctt_pkg::KIND_FIRED))
    |-> (out_handle != 16'd0))
    else $error("slot result with zero handle");

endmodule

bind callback_timer_table_core ctt_checker u_ctt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (req.valid),
  .in_ready   (req.ready),
  .in_opcode  (req.opcode),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .out_kind   (rsp.kind),
  .out_slot   (rsp.slot),
  .out_handle (rsp.fired_handle),
  .out_last   (rsp.last)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the callback timer table core.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctt_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int RAND_ITEMS = 340;
  localparam int IDLE_PCT = 18;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [15:0] handle;
    logic        last;
  } timer_result_t;

  // Keeps its own copy of the slot table and the results still due from the block.
  class timer_table_scoreboard;
    logic [15:0]   slot_handle[SLOTS];
    logic [9:0]    slot_period[SLOTS];
    logic          slot_rep[SLOTS];
    logic [9:0]    slot_count[SLOTS];
    timer_result_t due_results[$];
    int            errors;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        free_slot(i);
      end
      errors = 0;
    endfunction

    function void free_slot(int i);
      slot_handle[i] = '0;
      slot_period[i] = '0;
      slot_rep[i] = 1'b0;
      slot_count[i] = '0;
    endfunction

    function void add_result(kind_t k, int s, logic [15:0] h, logic l);
      timer_result_t r;
      r.kind = k;
      r.slot = s[2:0];
      r.handle = h;
      r.last = l;
      due_results.push_back(r);
    endfunction

    function void predict_tick();
      int fired;
      fired = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_handle[i] != '0) begin
          if (slot_count[i] == '0) begin
            if (fired < MAX_RESULTS) begin
              add_result(KIND_FIRED, i, slot_handle[i], 1'b0);
              fired++;
            end
            if (slot_rep[i]) begin
              slot_count[i] = slot_period[i];
            end else begin
              free_slot(i);
            end
          end else begin
            slot_count[i] = slot_count[i] - 10'd1;
          end
        end
      end
      if (fired == 0) begin
        add_result(KIND_IDLE, 0, '0, 1'b1);
      end else begin
        due_results[due_results.size() - 1].last = 1'b1;
      end
    endfunction

    function void predict_register(logic [15:0] h, logic [9:0] p, logic r);
      if (h != '0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_handle[i] == '0) begin
            slot_handle[i] = h;
            slot_period[i] = p;
            slot_rep[i] = r;
            slot_count[i] = p;
            add_result(KIND_REGISTERED, i, h, 1'b1);
            return;
          end
        end
      end
      add_result(KIND_FULL, 0, '0, 1'b1);
    endfunction

    function void predict_deregister(logic [15:0] h);
      if (h != '0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_handle[i] == h) begin
            free_slot(i);
            add_result(KIND_DEREGISTERED, i, h, 1'b1);
            return;
          end
        end
      end
      add_result(KIND_NOT_FOUND, 0, '0, 1'b1);
    endfunction

    function void note_request(logic [1:0] op, logic [15:0] h, logic [9:0] p, logic r);
      case (op)
        OP_TICK:  predict_tick();
        OP_REG:   predict_register(h, p, r);
        OP_DEREG: predict_deregister(h);
        default:  ;
      endcase
    endfunction

    function void check_result(timer_result_t got);
      timer_result_t want;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("unexpected result: kind=%0d slot=%0d handle=%h last=%b",
                   got.kind, got.slot, got.handle, got.last);
        end
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.slot !== want.slot ||
          got.handle !== want.handle || got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("mismatch: expected kind=%0d slot=%0d handle=%h last=%b, got kind=%0d slot=%0d handle=%h last=%b",
                   want.kind, want.slot, want.handle, want.last,
                   got.kind, got.slot, got.handle, got.last);
        end
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic quiet = 1'b0;
  int   rsp_hold = 0;
  timer_table_scoreboard sb;

  ctt_req_if req_ch();
  ctt_rsp_if rsp_ch();

  callback_timer_table_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: checks accepted items and throttles ready, including long hold-offs.
  initial begin
    timer_result_t got;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_ch.valid && rsp_ch.ready) begin
        got.kind = kind_t'(rsp_ch.kind);
        got.slot = rsp_ch.slot;
        got.handle = rsp_ch.fired_handle;
        got.last = rsp_ch.last;
        sb.check_result(got);
      end
      if (rsp_hold > 0) begin
        rsp_hold = rsp_hold - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_request(input logic [1:0] op, input logic [15:0] h,
                              input logic [9:0] p, input logic r);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.handle <= h;
    req_ch.period <= p;
    req_ch.repeat_req <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(op, h, p, r);
  endtask

  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int          pick;
    logic [1:0]  op;
    logic [15:0] h;
    logic [9:0]  p;
    sb = new();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.opcode = OP_TICK;
    req_ch.handle = '0;
    req_ch.period = '0;
    req_ch.repeat_req = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, zero handles, a missing handle and the unused opcode.
    send_request(OP_TICK, 16'h0000, 10'd0, 1'b0);
    send_request(OP_REG, 16'h0000, 10'd5, 1'b1);
    send_request(OP_DEREG, 16'h0000, 10'd0, 1'b0);
    send_request(OP_DEREG, 16'h1234, 10'd0, 1'b0);
    send_request(OP_UNUSED, 16'hFFFF, 10'd1023, 1'b1);
    // One-shot and periodic entries at both period extremes.
    send_request(OP_REG, 16'hFFFF, 10'd1023, 1'b1);
    send_request(OP_REG, 16'h0001, 10'd0, 1'b0);
    send_request(OP_REG, 16'hA5A5, 10'd0, 1'b1);
    send_request(OP_REG, 16'h5A5A, 10'd1, 1'b0);
    send_request(OP_TICK, 16'h0000, 10'd0, 1'b0);
    send_request(OP_TICK, 16'h0000, 10'd0, 1'b0);
    // A duplicate handle; deregister must free the lowest matching slot.
    send_request(OP_REG, 16'hA5A5, 10'd2, 1'b1);
    send_request(OP_DEREG, 16'hA5A5, 10'd0, 1'b0);
    // Fill the table with always-firing periodic entries, then overflow it.
    send_request(OP_REG, 16'h8000, 10'd0, 1'b1);
    send_request(OP_REG, 16'h4000, 10'd0, 1'b1);
    send_request(OP_REG, 16'h2000, 10'd0, 1'b1);
    send_request(OP_REG, 16'h0F0F, 10'd0, 1'b1);
    send_request(OP_REG, 16'h3C3C, 10'd0, 1'b1);
    send_request(OP_REG, 16'h7FFE, 10'd0, 1'b1);
    send_request(OP_REG, 16'h1111, 10'd3, 1'b0);
    send_request(OP_DEREG, 16'hFFFF, 10'd0, 1'b0);
    send_request(OP_REG, 16'h00FF, 10'd0, 1'b1);
    // Every slot fires on the same tick.
    send_request(OP_TICK, 16'h0000, 10'd0, 1'b0);
    send_request(OP_TICK, 16'h0000, 10'd0, 1'b0);
    wait_results_done();

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 60) quiet = 1'b1;
      if (n == 140) quiet = 1'b0;
      // The block holds its current item behind a long result stall while requests keep coming.
      if (n == 200) rsp_hold = 160;
      if (n == 280) wait_results_done();

      if ($urandom_range(0, 99) < 4) begin
        send_request(OP_UNUSED, 16'($urandom_range(0, 65535)),
                     10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      end

      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 70) begin
        p = 10'($urandom_range(0, 4));
      end else begin
        p = 10'($urandom_range(0, 1023));
      end
      if (pick < 40) begin
        op = OP_TICK;
        h = 16'($urandom_range(0, 65535));
      end else if (pick < 72) begin
        op = OP_REG;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          h = '0;
        end else if (pick < 15) begin
          h = sb.slot_handle[$urandom_range(0, SLOTS - 1)];
        end else begin
          h = 16'($urandom_range(1, 65535));
        end
      end else begin
        op = OP_DEREG;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          h = sb.slot_handle[$urandom_range(0, SLOTS - 1)];
        end else if (pick < 80) begin
          h = '0;
        end else begin
          h = 16'($urandom_range(1, 65535));
        end
      end
      send_request(op, h, p, 1'($urandom_range(0, 1)));
    end

    wait_results_done();
    repeat (SLOTS + 16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
